FILE: hdl/rpn_stack_evaluator_top_defines.svh
// Assertion macros shared by the evaluator's checking code.
`ifndef RPN_STACK_EVALUATOR_TOP_DEFINES_SVH
`define RPN_STACK_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RSE_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSE_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

FILE: hdl/rse_pkg.sv
// Types and constants shared by the RPN stack evaluator modules.
package rse_pkg;

  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 16;

  // Raw function codes on the input port.
  localparam logic [2:0] FUNC_PUSH   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_MUL    = 3'd2;
  localparam logic [2:0] FUNC_SUB    = 3'd3;
  localparam logic [2:0] FUNC_FINISH = 3'd4;

  // Status codes reported with every result item.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_OVERFLOW     = 3'd1;
  localparam logic [2:0] ST_INSUFFICIENT = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED  = 3'd3;
  localparam logic [2:0] ST_NO_RESULT    = 3'd4;
  localparam logic [2:0] ST_TOO_MANY     = 3'd5;

  // Decoded operation carried from the front end to the stack engine.
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_MUL    = 3'd2,
    OP_SUB    = 3'd3,
    OP_FINISH = 3'd4,
    OP_BAD    = 3'd5
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

FILE: hdl/rse_front.sv
// Front end: accepts input items and decodes the function code into a command.
module rse_front import rse_pkg::*; (
  input  logic                      push,
  output logic                      full,
  input  logic [2:0]                func,
  input  logic signed [VALUE_W-1:0] operand_value,
  input  logic                      q_full,
  output logic                      q_push,
  output cmd_t                      q_cmd
);

  // Back pressure comes straight from the command queue.
  assign full   = q_full;
  assign q_push = push && !q_full;

  // Decode the function code; codes above finish are unsupported.
  always_comb begin
    q_cmd.value = operand_value;
    case (func)
      FUNC_PUSH:   q_cmd.op = OP_PUSH;
      FUNC_ADD:    q_cmd.op = OP_ADD;
      FUNC_MUL:    q_cmd.op = OP_MUL;
      FUNC_SUB:    q_cmd.op = OP_SUB;
      FUNC_FINISH: q_cmd.op = OP_FINISH;
      default:     q_cmd.op = OP_BAD;
    endcase
  end

endmodule

FILE: hdl/rse_queue.sv
// Two-entry command queue between the front end and the stack engine.
module rse_queue import rse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full_flag,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty_flag
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full_flag  = (fill == 2'd2);
  assign empty_flag = (fill == 2'd0);
  assign rd_cmd     = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_cmd;
  end

endmodule

FILE: hdl/rse_back.sv
// Stack engine: executes commands on the operand stack and holds the result item.
module rse_back import rse_pkg::*; #(
  parameter int STACK_DEPTH   = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                status,
  output logic signed [VALUE_W-1:0] top_value,
  output logic signed [TOTAL_W-1:0] total_integer,
  output logic                      finished,
  output logic [3:0]                depth
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [TOTAL_W-1:0] TMAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TMIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_MUL  = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  cmd_t                         cur;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [2:0]                   held;
  logic [2:0]                   held_next;
  logic signed [VALUE_W-1:0]    top_reg;
  logic signed [VALUE_W-1:0]    top_next;
  logic signed [VALUE_W-1:0]    store [STACK_DEPTH];
  logic signed [VALUE_W-1:0]    rd_data;
  logic signed [2*VALUE_W-1:0]  prod;
  logic                         out_valid;
  logic                         commit;
  logic                         mem_we;
  logic [2:0]                   status_c;
  logic signed [TOTAL_W-1:0]    total_c;
  logic signed [VALUE_W:0]      sum_w;
  logic signed [VALUE_W-1:0]    sum_sat;
  logic [2*VALUE_W-1:0]         pmag;
  logic [2*VALUE_W-1:0]         pshift;
  logic signed [VALUE_W-1:0]    mul_sat;
  logic signed [VALUE_W-1:0]    alu_r;
  logic [VALUE_W-1:0]           tmag;
  logic [VALUE_W-1:0]           tshift;
  logic signed [TOTAL_W-1:0]    trunc_int;

  assign empty = !out_valid;

  // Sequencing: take a command, wait for the operand read, optionally multiply.
  always_comb begin
    q_pop      = 1'b0;
    state_next = state;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (cur.op == OP_MUL) begin
          state_next = S_MUL;
        end else if (!out_valid || pop) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (!out_valid || pop) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Saturating add or subtract of the second entry and the top entry.
  always_comb begin
    if (cur.op == OP_SUB) begin
      sum_w = {rd_data[VALUE_W-1], rd_data} - {top_reg[VALUE_W-1], top_reg};
    end else begin
      sum_w = {rd_data[VALUE_W-1], rd_data} + {top_reg[VALUE_W-1], top_reg};
    end
    if (sum_w[VALUE_W] != sum_w[VALUE_W-1]) begin
      sum_sat = sum_w[VALUE_W] ? VMIN : VMAX;
    end else begin
      sum_sat = sum_w[VALUE_W-1:0];
    end
  end

  // Product rescale: shift the magnitude so that rounding is toward zero, then saturate.
  always_comb begin
    pmag   = prod[2*VALUE_W-1] ? (2*VALUE_W)'(-prod) : prod;
    pshift = pmag >> FRACTION_BITS;
    if (prod[2*VALUE_W-1]) begin
      if (pshift > (2*VALUE_W)'(64'h0000_0000_8000_0000)) begin
        mul_sat = VMIN;
      end else begin
        mul_sat = VALUE_W'((2*VALUE_W)'(0) - pshift);
      end
    end else begin
      if (pshift > (2*VALUE_W)'(64'h0000_0000_7FFF_FFFF)) begin
        mul_sat = VMAX;
      end else begin
        mul_sat = VALUE_W'(pshift);
      end
    end
  end

  assign alu_r = (state == S_MUL) ? mul_sat : sum_sat;

  // Integer part of the top entry, truncated toward zero and saturated.
  always_comb begin
    tmag   = top_reg[VALUE_W-1] ? (VALUE_W)'(-top_reg) : top_reg;
    tshift = tmag >> FRACTION_BITS;
    if (top_reg[VALUE_W-1]) begin
      if (tshift > VALUE_W'(32768)) begin
        trunc_int = TMIN;
      end else begin
        trunc_int = TOTAL_W'(VALUE_W'(0) - tshift);
      end
    end else begin
      if (tshift > VALUE_W'(32767)) begin
        trunc_int = TMAX;
      end else begin
        trunc_int = TOTAL_W'(tshift);
      end
    end
  end

  // Command execution: stack update, held error and status of the result item.
  always_comb begin
    status_c   = ST_OK;
    total_c    = '0;
    count_next = count;
    held_next  = held;
    top_next   = top_reg;
    mem_we     = 1'b0;
    if (cur.op == OP_FINISH) begin
      if (held != ST_OK) begin
        status_c = held;
      end else if (count == '0) begin
        status_c = ST_NO_RESULT;
      end else if (count != CW'(1)) begin
        status_c = ST_TOO_MANY;
      end else begin
        total_c = trunc_int;
      end
      count_next = '0;
      held_next  = ST_OK;
    end else if (held != ST_OK) begin
      status_c = held;
    end else begin
      case (cur.op)
        OP_PUSH: begin
          if (count >= CW'(STACK_DEPTH)) begin
            held_next = ST_OVERFLOW;
            status_c  = ST_OVERFLOW;
          end else begin
            mem_we     = (count != '0);
            top_next   = cur.value;
            count_next = count + CW'(1);
          end
        end
        OP_ADD, OP_MUL, OP_SUB: begin
          if (count < CW'(2)) begin
            held_next = ST_INSUFFICIENT;
            status_c  = ST_INSUFFICIENT;
          end else begin
            top_next   = alu_r;
            count_next = count - CW'(1);
          end
        end
        default: begin
          held_next = ST_UNSUPPORTED;
          status_c  = ST_UNSUPPORTED;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      held      <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operand store: the top entry lives in top_reg, the rest below it in memory.
  always_ff @(posedge clk) begin
    if (commit && mem_we) store[AW'(count - CW'(1))] <= top_reg;
    rd_data <= store[AW'(count - CW'(2))];
  end

  // Payload registers: current command, product, top entry and result item.
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    prod <= (2*VALUE_W)'(rd_data) * (2*VALUE_W)'(top_reg);
    if (commit) begin
      top_reg       <= top_next;
      status        <= status_c;
      top_value     <= (count_next != '0) ? top_next : '0;
      total_integer <= total_c;
      finished      <= (cur.op == OP_FINISH);
      depth         <= 4'(count_next);
    end
  end

endmodule

FILE: hdl/rpn_stack_evaluator_top.sv
// Top level of the RPN stack evaluator: front end, command queue and stack engine.
//
//  Channel   Handshake          Payload
//  input     push / full        func, operand_value
//  result    pop / empty        status, top_value, total_integer, finished, depth
//
// In the stack engine S_IDLE takes the command and starts the operand read, S_READ
// uses the registered read and loads the result item, or on a multiply S_MUL loads
// it from the registered product; the load waits while a result is held. The two-entry
// command queue takes new items while the engine works or a result waits. Reset
// (rst, synchronous) empties the queue, the stack and the held error. A result held
// on the port stalls only the engine, not the input until the queue fills.
`include "rpn_stack_evaluator_top_defines.svh"
module rpn_stack_evaluator_top import rse_pkg::*; #(
  parameter int STACK_DEPTH   = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [2:0]                func,
  input  logic signed [VALUE_W-1:0] operand_value,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                status,
  output logic signed [VALUE_W-1:0] top_value,
  output logic signed [TOTAL_W-1:0] total_integer,
  output logic                      finished,
  output logic [3:0]                depth
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  // Input decode.
  rse_front u_front (
    .push          (push),
    .full          (full),
    .func          (func),
    .operand_value (operand_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (wr_cmd)
  );

  // Command queue.
  rse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (q_push),
    .wr_cmd     (wr_cmd),
    .full_flag  (q_full),
    .rd_en      (q_pop),
    .rd_cmd     (rd_cmd),
    .empty_flag (q_empty)
  );

  // Stack engine.
  rse_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cmd         (rd_cmd),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .top_value     (top_value),
    .total_integer (total_integer),
    .finished      (finished),
    .depth         (depth)
  );

  // A finish always leaves the stack empty.
  `RSE_CHECK(a_finish_clears, (!empty && finished) |-> (depth == 4'd0 && top_value == '0), "finish left entries on the stack")
  // Only a finish carries an integer answer.
  `RSE_CHECK(a_total_only_finish, (!empty && !finished) |-> (total_integer == '0), "integer answer on a non-finish item")
  // An accepted item is held in the queue afterwards.
  `RSE_CHECK_NEXT(a_item_queued, (push && !full), !q_empty, "accepted item missing from the queue")

endmodule
